/* rtl/core/ehkd_pkg.sv */
// Shared types, constants and SHA-512 helper functions for the key derivation block.
`default_nettype none
package ehkd_pkg;

    localparam int SEED_WORDS = 8;
    localparam int REG_IDX_W  = 3;
    localparam int SEG_W      = 31;
    localparam logic [31:0] HARDENED_OFFSET = 32'h8000_0000;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MSTART,
        ST_MRUN,
        ST_LOAD,
        ST_CSTART,
        ST_CRUN,
        ST_EMIT
    } state_t;

    // Which HMAC the datapath runs.
    typedef enum logic [0:0] {
        JOB_MASTER,
        JOB_CHILD
    } job_t;

    typedef struct packed {
        logic start;
        job_t job;
        logic load_master;
    } dp_cmd_t;

    typedef struct packed {
        logic done;
    } dp_sts_t;

    function automatic logic [63:0] round_k(input logic [6:0] t);
        logic [63:0] k;
        unique case (t)
            7'd0: k = 64'h428a2f98d728ae22; 7'd1: k = 64'h7137449123ef65cd;
            7'd2: k = 64'hb5c0fbcfec4d3b2f; 7'd3: k = 64'he9b5dba58189dbbc;
            7'd4: k = 64'h3956c25bf348b538; 7'd5: k = 64'h59f111f1b605d019;
            7'd6: k = 64'h923f82a4af194f9b; 7'd7: k = 64'hab1c5ed5da6d8118;
            7'd8: k = 64'hd807aa98a3030242; 7'd9: k = 64'h12835b0145706fbe;
            7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
            7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
            7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
            7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
            7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
            7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
            7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
            7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
            7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
            7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
            7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
            7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
            7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
            7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
            7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
            7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
            7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
            7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
            7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
            7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
            7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
            7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
            7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
            7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
            7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
            7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
            7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
            7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
            7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
            7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
            7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
            7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
            7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
            7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
            7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
            default: k = 64'h0;
        endcase
        return k;
    endfunction

    function automatic logic [511:0] initial_hash();
        return {64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
                64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
                64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};
    endfunction

    // "ed25519 seed" padded with zeros to a full 128-byte block.
    localparam logic [1023:0] CURVE_KEY = {96'h6564_3235_3531_3920_7365_6564, 928'h0};

endpackage
`default_nettype wire

/* rtl/core/ed25519_hardened_key_derivation.sv */
// Top level of the hardened ed25519 key derivation block.
// Each path segment word with apply_step set runs one HMAC-SHA512 of four SHA-512
// compressions on a single round-per-cycle engine; a segment that starts a path after a
// seed write first recomputes the master pair, four compressions more. The block takes
// one word at a time; a word with last set holds the 256-bit key on the m_ side until
// taken. Seed registers are written by index 0..7.
`default_nettype none
module ed25519_hardened_key_derivation (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [63:0]  cfg_data,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [31:0]  s_tdata,   // path_segment[30:0], apply_step[31]
    input  wire logic         s_tuser,   // first_segment
    input  wire logic         s_tlast,   // last_segment
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [255:0]      m_tdata    // key_word_0 .. key_word_3
);

    logic [63:0]        seed_reg [ehkd_pkg::SEED_WORDS];
    logic [30:0]        seg_reg;
    logic               in_fire;
    ehkd_pkg::dp_cmd_t  cmd;
    ehkd_pkg::dp_sts_t  sts;
    logic [255:0]       cur_key;

    assign in_fire = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ehkd_pkg::SEED_WORDS; i++) begin
                seed_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            seed_reg[cfg_index] <= cfg_data;
        end
        if (in_fire) begin
            seg_reg <= s_tdata[30:0];
        end
    end

    ehkd_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .first     (s_tuser),
        .last      (s_tlast),
        .apply     (s_tdata[31]),
        .seed_wr   (cfg_we),
        .out_ready (m_tready),
        .sts       (sts),
        .cmd       (cmd),
        .in_ready  (s_tready),
        .out_valid (m_tvalid)
    );

    ehkd_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .seed_word (seed_reg),
        .segment   (seg_reg),
        .cmd       (cmd),
        .sts       (sts),
        .cur_key   (cur_key)
    );

    assign m_tdata = {cur_key[63:0], cur_key[127:64], cur_key[191:128], cur_key[255:192]};

endmodule
`default_nettype wire

/* rtl/core/ehkd_sha_core.sv */
// SHA-512 compression engine: one round per cycle, schedule in a 16-word shift window.
`default_nettype none
module ehkd_sha_core (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [511:0]  chain_in,
    input  wire logic [1023:0] block_in,
    output logic               done,
    output logic [511:0]       hash_out
);

    logic [63:0]  w_reg [16];
    logic [63:0]  w_next [16];
    logic [63:0]  v_reg [8];
    logic [63:0]  v_next [8];
    logic [511:0] h_reg, h_next;
    logic [6:0]   t_reg, t_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [63:0]  s0, s1, wt, t1, t2, ch, maj, e0, e1;
    logic [63:0]  round_k_w;

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    assign round_k_w = ehkd_pkg::round_k(t_reg);

    always_comb begin
        s0 = rotr(w_reg[1], 1) ^ rotr(w_reg[1], 8) ^ (w_reg[1] >> 7);
        s1 = rotr(w_reg[14], 19) ^ rotr(w_reg[14], 61) ^ (w_reg[14] >> 6);
        // Window holds W[t..t+15]; W[t] is at index 0.
        wt = w_reg[0];
        e1 = rotr(v_reg[4], 14) ^ rotr(v_reg[4], 18) ^ rotr(v_reg[4], 41);
        ch = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1 = v_reg[7] + e1 + ch + round_k_w + wt;
        e0 = rotr(v_reg[0], 28) ^ rotr(v_reg[0], 34) ^ rotr(v_reg[0], 39);
        maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2 = e0 + maj;
    end

    always_comb begin
        w_next = w_reg;
        v_next = v_reg;
        h_next = h_reg;
        t_next = t_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            for (int i = 0; i < 16; i++) begin
                w_next[i] = block_in[1023 - 64*i -: 64];
            end
            for (int i = 0; i < 8; i++) begin
                v_next[i] = chain_in[511 - 64*i -: 64];
            end
            h_next = chain_in;
            t_next = 7'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            for (int i = 0; i < 15; i++) begin
                w_next[i] = w_reg[i+1];
            end
            w_next[15] = s1 + w_reg[9] + s0 + w_reg[0];
            v_next[7] = v_reg[6]; v_next[6] = v_reg[5]; v_next[5] = v_reg[4];
            v_next[4] = v_reg[3] + t1;
            v_next[3] = v_reg[2]; v_next[2] = v_reg[1]; v_next[1] = v_reg[0];
            v_next[0] = t1 + t2;
            t_next = t_reg + 7'd1;
            if (t_reg == 7'd79) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                for (int i = 0; i < 8; i++) begin
                    h_next[511 - 64*i -: 64] = h_reg[511 - 64*i -: 64] + v_next[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        w_reg <= w_next;
        v_reg <= v_next;
        h_reg <= h_next;
        t_reg <= t_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign hash_out = h_reg;

endmodule
`default_nettype wire

/* rtl/core/ehkd_datapath.sv */
// HMAC datapath: key and chain registers, block builder and a four-pass compression sequence.
`default_nettype none
module ehkd_datapath (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [63:0]       seed_word [ehkd_pkg::SEED_WORDS],
    input  wire logic [30:0]       segment,
    input  ehkd_pkg::dp_cmd_t      cmd,
    output ehkd_pkg::dp_sts_t      sts,
    output logic [255:0]           cur_key
);

    // An HMAC is four compressions: inner pad, padded inner message, outer pad and
    // padded outer digest. Both the seed and the child message fit one block with padding.
    logic [255:0]  mkey_reg, mchain_reg;
    logic [255:0]  ckey_reg, cchain_reg;
    logic [511:0]  inner_reg;
    logic [2:0]    pass_reg;
    logic          run_reg;
    ehkd_pkg::job_t job_reg;
    logic          sha_start;
    logic          sha_done;
    logic [511:0]  sha_out;
    logic [511:0]  sha_chain;
    logic [1023:0] sha_block;
    logic [1023:0] hkey;
    logic [1023:0] child_msg;
    logic [1023:0] seed_blk;
    logic [31:0]   idx;
    logic          last_pass;
    logic          start_reg;

    assign idx = {1'b0, segment} | ehkd_pkg::HARDENED_OFFSET;
    assign hkey = (job_reg == ehkd_pkg::JOB_MASTER) ? ehkd_pkg::CURVE_KEY
                                                    : {cchain_reg, 768'h0};

    // Seed then padding; total HMAC inner length 128+64 bytes = 1536 bits.
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            seed_blk[1023 - 64*i -: 64] = seed_word[i];
        end
        seed_blk[511:0] = {8'h80, 376'h0, 128'd1536};
    end

    // 0x00 | key | index | 0x80 pad; total HMAC inner length 128+37 bytes = 1320 bits.
    assign child_msg = {8'h00, ckey_reg, idx, 8'h80, 592'h0, 128'd1320};

    always_comb begin
        sha_chain = (pass_reg == 3'd0 || pass_reg == 3'd3) ? ehkd_pkg::initial_hash()
                                                           : sha_out;
        unique case (pass_reg)
            3'd0: sha_block = hkey ^ {128{8'h36}};
            3'd1: sha_block = (job_reg == ehkd_pkg::JOB_MASTER) ? seed_blk : child_msg;
            3'd3: sha_block = hkey ^ {128{8'h5c}};
            3'd4: sha_block = {inner_reg, 8'h80, 376'h0, 128'd1536};
            default: sha_block = 1024'h0;
        endcase
    end

    assign sha_start = start_reg;
    assign last_pass = (pass_reg == 3'd4);

    ehkd_sha_core u_sha (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sha_start),
        .chain_in (sha_chain),
        .block_in (sha_block),
        .done     (sha_done),
        .hash_out (sha_out)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg   <= 1'b0;
            start_reg <= 1'b0;
            pass_reg  <= 3'd0;
            job_reg   <= ehkd_pkg::JOB_MASTER;
            mkey_reg  <= '0;
            mchain_reg <= '0;
        end else begin
            start_reg <= cmd.start || (run_reg && sha_done && !last_pass);
            if (cmd.start) begin
                job_reg   <= cmd.job;
                pass_reg  <= 3'd0;
                run_reg   <= 1'b1;
            end else if (run_reg && sha_done) begin
                if (last_pass) begin
                    run_reg <= 1'b0;
                    if (job_reg == ehkd_pkg::JOB_MASTER) begin
                        mkey_reg   <= sha_out[511:256];
                        mchain_reg <= sha_out[255:0];
                    end else begin
                        ckey_reg   <= sha_out[511:256];
                        cchain_reg <= sha_out[255:0];
                    end
                end else if (pass_reg == 3'd1) begin
                    inner_reg <= sha_out;
                    pass_reg  <= 3'd3;
                end else begin
                    pass_reg <= pass_reg + 3'd1;
                end
            end
            if (cmd.load_master) begin
                ckey_reg   <= mkey_reg;
                cchain_reg <= mchain_reg;
            end
        end
    end

    assign sts.done = run_reg && sha_done && last_pass;
    assign cur_key = ckey_reg;

endmodule
`default_nettype wire

/* rtl/core/ehkd_ctrl.sv */
// Controller state machine: master refresh, path start, child step and result word.
`default_nettype none
module ehkd_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_fire,
    input  wire logic          first,
    input  wire logic          last,
    input  wire logic          apply,
    input  wire logic          seed_wr,
    input  wire logic          out_ready,
    input  ehkd_pkg::dp_sts_t  sts,
    output ehkd_pkg::dp_cmd_t  cmd,
    output logic               in_ready,
    output logic               out_valid
);

    ehkd_pkg::state_t state_reg, state_next;
    logic mvalid_reg, mvalid_next;
    logic apply_reg, last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ehkd_pkg::ST_IDLE;
            mvalid_reg <= 1'b0;
            apply_reg  <= 1'b0;
            last_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
            if (in_fire) begin
                apply_reg <= apply;
                last_reg  <= last;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        mvalid_next = mvalid_reg;
        if (seed_wr) begin
            mvalid_next = 1'b0;
        end
        unique case (state_reg)
            ehkd_pkg::ST_IDLE: begin
                if (in_fire) begin
                    if (first && !mvalid_reg) begin
                        state_next = ehkd_pkg::ST_MSTART;
                    end else if (first) begin
                        state_next = ehkd_pkg::ST_LOAD;
                    end else if (apply) begin
                        state_next = ehkd_pkg::ST_CSTART;
                    end else if (last) begin
                        state_next = ehkd_pkg::ST_EMIT;
                    end
                end
            end
            ehkd_pkg::ST_MSTART: state_next = ehkd_pkg::ST_MRUN;
            ehkd_pkg::ST_MRUN: begin
                if (sts.done) begin
                    mvalid_next = 1'b1;
                    state_next = ehkd_pkg::ST_LOAD;
                end
            end
            ehkd_pkg::ST_LOAD: begin
                if (apply_reg) begin
                    state_next = ehkd_pkg::ST_CSTART;
                end else if (last_reg) begin
                    state_next = ehkd_pkg::ST_EMIT;
                end else begin
                    state_next = ehkd_pkg::ST_IDLE;
                end
            end
            ehkd_pkg::ST_CSTART: state_next = ehkd_pkg::ST_CRUN;
            ehkd_pkg::ST_CRUN: begin
                if (sts.done) begin
                    state_next = last_reg ? ehkd_pkg::ST_EMIT : ehkd_pkg::ST_IDLE;
                end
            end
            ehkd_pkg::ST_EMIT: begin
                if (out_ready) begin
                    state_next = ehkd_pkg::ST_IDLE;
                end
            end
            default: state_next = ehkd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        cmd.job = ehkd_pkg::JOB_CHILD;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ehkd_pkg::ST_IDLE: in_ready = 1'b1;
            ehkd_pkg::ST_MSTART: begin
                cmd.start = 1'b1;
                cmd.job = ehkd_pkg::JOB_MASTER;
            end
            ehkd_pkg::ST_MRUN: ;
            ehkd_pkg::ST_LOAD: cmd.load_master = 1'b1;
            ehkd_pkg::ST_CSTART: cmd.start = 1'b1;
            ehkd_pkg::ST_CRUN: ;
            ehkd_pkg::ST_EMIT: out_valid = 1'b1;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

/* verif/ehkd_checker.sv */
// Checker for the key derivation block: predicts derived keys and compares output words.
`default_nettype none
module ehkd_checker (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [63:0]  cfg_data,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [31:0]  s_tdata,   // path_segment[30:0], apply_step[31]
    input  wire logic         s_tuser,   // first_segment
    input  wire logic         s_tlast,   // last_segment
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [255:0] m_tdata,   // key_word_0 .. key_word_3
    output int                fail_count,
    output int                pending_keys,
    output int                keys_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] SHA_K [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };
    localparam logic [511:0] SHA_IV = {
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };
    // "ed25519 seed", zero filled to one block.
    localparam logic [1023:0] MASTER_HMAC_KEY = {96'h656432353531392073656564, 928'h0};

    logic [63:0]  seed_reg [8];
    logic [255:0] master_key, master_chain, path_key, path_chain;
    bit           master_ok;
    logic [255:0] key_queue [$];

    function automatic logic [63:0] rotr64(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    function automatic logic [511:0] sha_compress(input logic [511:0] h,
                                                  input logic [1023:0] blk);
        logic [63:0] w [16];
        logic [63:0] v [8];
        logic [63:0] wt, t1, t2, a2, a15;
        logic [511:0] res;
        for (int i = 0; i < 16; i++) w[i] = blk[1023 - 64 * i -: 64];
        for (int i = 0; i < 8; i++) v[i] = h[511 - 64 * i -: 64];
        for (int t = 0; t < 80; t++) begin
            if (t < 16) begin
                wt = w[t];
            end else begin
                a2  = w[(t - 2) & 15];
                a15 = w[(t - 15) & 15];
                wt = (rotr64(a2, 19) ^ rotr64(a2, 61) ^ (a2 >> 6)) + w[(t - 7) & 15]
                   + (rotr64(a15, 1) ^ rotr64(a15, 8) ^ (a15 >> 7)) + w[t & 15];
                w[t & 15] = wt;
            end
            t1 = v[7] + (rotr64(v[4], 14) ^ rotr64(v[4], 18) ^ rotr64(v[4], 41))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[t] + wt;
            t2 = (rotr64(v[0], 28) ^ rotr64(v[0], 34) ^ rotr64(v[0], 39))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) res[511 - 64 * i -: 64] = h[511 - 64 * i -: 64] + v[i];
        return res;
    endfunction

    // Digest of a left-aligned message of 129 to 192 bytes: always two blocks once padded.
    function automatic logic [511:0] sha_two_blocks(input logic [1535:0] msg, input int len);
        logic [2047:0] padded;
        logic [511:0]  h;
        padded = {msg, 512'h0};
        padded[2047 - 8 * len -: 8] = 8'h80;
        padded[127:0] = 128'(len * 8);
        h = sha_compress(SHA_IV, padded[2047:1024]);
        return sha_compress(h, padded[1023:0]);
    endfunction

    function automatic logic [511:0] keyed_digest(input logic [1023:0] hkey,
                                                  input logic [511:0] msg, input int len);
        logic [511:0] inner;
        inner = sha_two_blocks({hkey ^ {128{8'h36}}, msg}, 128 + len);
        return sha_two_blocks({hkey ^ {128{8'h5c}}, inner}, 192);
    endfunction

    function automatic logic [255:0] key_to_tdata(input logic [255:0] k);
        return {k[63:0], k[127:64], k[191:128], k[255:192]};
    endfunction

    task automatic step_path(input logic [30:0] seg, input bit first, input bit last,
                             input bit apply);
        logic [511:0] mac;
        if (first) begin
            if (!master_ok) begin
                mac = keyed_digest(MASTER_HMAC_KEY, {seed_reg[0], seed_reg[1], seed_reg[2],
                                   seed_reg[3], seed_reg[4], seed_reg[5], seed_reg[6],
                                   seed_reg[7]}, 64);
                master_key   = mac[511:256];
                master_chain = mac[255:0];
                master_ok    = 1'b1;
            end
            path_key   = master_key;
            path_chain = master_chain;
        end
        if (apply) begin
            // 0x00, key, then the hardened index big-endian: 37 bytes.
            mac = keyed_digest({path_chain, 768'h0}, {8'h00, path_key, 1'b1, seg, 216'h0}, 37);
            path_key   = mac[511:256];
            path_chain = mac[255:0];
        end
        if (last) key_queue.push_back(key_to_tdata(path_key));
    endtask

    always @(posedge aclk) begin
        logic [255:0] want;
        if (!aresetn) begin
            foreach (seed_reg[i]) seed_reg[i] = '0;
            master_key   = '0;
            master_chain = '0;
            path_key     = '0;
            path_chain   = '0;
            master_ok    = 1'b0;
            key_queue.delete();
        end else begin
            if (cfg_we) begin
                seed_reg[cfg_index] = cfg_data;
                master_ok = 1'b0;
            end
            if (s_tvalid && s_tready)
                step_path(s_tdata[30:0], s_tuser, s_tlast, s_tdata[31]);
            if (m_tvalid && m_tready) begin
                keys_checked++;
                if (key_queue.size() == 0) begin
                    fail_count++;
                    $display("%0t: key word with none expected: %h", $time, m_tdata);
                end else begin
                    want = key_queue.pop_front();
                    for (int i = 0; i < 4; i++)
                        if (m_tdata[64 * i +: 64] !== want[64 * i +: 64]) begin
                            fail_count++;
                            $display("%0t: key_word_%0d expected %h actual %h", $time, i,
                                     want[64 * i +: 64], m_tdata[64 * i +: 64]);
                        end
                end
            end
        end
        pending_keys <= key_queue.size();
    end

    initial begin
        fail_count   = 0;
        keys_checked = 0;
        pending_keys = 0;
    end
endmodule
`default_nettype wire

/* verif/tb_top.sv */
// Top of the key derivation testbench: clock, reset, seed writes, path words and verdict.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic                           aclk, aresetn;
    logic                           cfg_we;
    logic [ehkd_pkg::REG_IDX_W-1:0] cfg_index;
    logic [63:0]                    cfg_data;
    logic                           s_tvalid, s_tready, s_tuser, s_tlast;
    logic [31:0]                    s_tdata;
    logic                           m_tvalid, m_tready;
    logic [255:0]                   m_tdata;
    int                             fail_count, pending_keys, keys_checked;
    int                             words_sent, burst_left, seed_sets;

    ed25519_hardened_key_derivation dut (.*);

    ehkd_checker chk (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_data, .s_tvalid, .s_tready, .s_tdata,
        .s_tuser, .s_tlast, .m_tvalid, .m_tready, .m_tdata, .fail_count, .pending_keys,
        .keys_checked
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("Regression FAIL");
        $finish;
    end

    // Receiver alternates between free flow, long stalls and random back-pressure.
    always @(posedge aclk) begin
        int mode, left;
        if (left == 0) begin
            mode = $urandom_range(0, 2);
            left = $urandom_range(1, 600);
        end
        left--;
        m_tready <= (mode == 0) ? 1'b1 : (mode == 1) ? 1'b0 : ($urandom_range(0, 3) == 0);
    end

    task automatic send_word(input logic [30:0] seg, input bit first, input bit last,
                             input bit apply);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge aclk);
            burst_left = $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {apply, seg};
        s_tuser  <= first;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        words_sent++;
    endtask

    // Quiet the sender, let the block drain, then load a new seed.
    task automatic load_seed(input int kind);
        logic [63:0] v;
        s_tvalid <= 1'b0;
        while (pending_keys != 0) @(posedge aclk);
        repeat (1000) @(posedge aclk);
        for (int i = 0; i < ehkd_pkg::SEED_WORDS; i++) begin
            v = (kind == 0) ? 64'h0 : (kind == 1) ? '1 : {$urandom, $urandom};
            // Partial reload keeps some words from the last seed.
            if (kind == 3 && i[0]) continue;
            @(posedge aclk);
            cfg_we    <= 1'b1;
            cfg_index <= i[ehkd_pkg::REG_IDX_W-1:0];
            cfg_data  <= v;
        end
        @(posedge aclk);
        cfg_we <= 1'b0;
        seed_sets++;
    endtask

    function automatic logic [30:0] rand_seg();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return 31'(1) << $urandom_range(0, 30);
            default: return 31'($urandom);
        endcase
    endfunction

    initial begin
        int len;
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        s_tlast   <= 1'b0;
        m_tready  <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset seed, then the standard four-segment wallet path.
        send_word(31'd44, 1, 0, 1);
        send_word(31'd501, 0, 0, 1);
        send_word(31'd7, 0, 0, 1);
        send_word(31'd0, 0, 1, 1);
        // Empty path emits the master key; extreme segments; pass-through mid path.
        send_word(31'd0, 1, 1, 0);
        send_word('1, 1, 1, 1);
        send_word('0, 0, 1, 1);
        send_word(31'h5555_5555, 0, 0, 0);
        send_word(31'h2aaa_aaaa, 0, 1, 1);
        load_seed(1);
        send_word(31'd0, 1, 1, 0);
        send_word(31'd44, 1, 0, 1);
        send_word(31'd501, 0, 1, 1);
        send_word(31'd0, 0, 1, 0);
        // Restart from the master in the middle of a path.
        send_word('1, 0, 0, 1);
        send_word(31'd44, 1, 1, 1);
        load_seed(0);
        send_word(31'd1, 1, 1, 1);

        for (int phase = 0; phase < 5; phase++) begin
            load_seed(phase == 3 ? 3 : 2);
            while (words_sent < 20 + 200 * (phase + 1)) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 10)
                                                  : $urandom_range(1, 5);
                // Now and then continue the current pair instead of restarting.
                for (int k = 0; k < len; k++)
                    send_word(rand_seg(), k == 0 && $urandom_range(0, 7) != 0,
                              k == len - 1 || $urandom_range(0, 9) == 0,
                              $urandom_range(0, 9) != 0);
            end
        end

        s_tvalid <= 1'b0;
        while (pending_keys != 0) @(posedge aclk);
        repeat (1000) @(posedge aclk);
        $display("Sent %0d path words under %0d seed settings; %0d keys checked.",
                 words_sent, seed_sets, keys_checked);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire

/* files.f */
rtl/core/ehkd_pkg.sv
rtl/core/ehkd_sha_core.sv
rtl/core/ehkd_datapath.sv
rtl/core/ehkd_ctrl.sv
rtl/core/ed25519_hardened_key_derivation.sv
verif/ehkd_checker.sv
verif/tb_top.sv
